// ----- src/fsc_pkg.sv -----
// fan speed controller shared types, constants and helpers
`default_nettype none

package fsc_pkg;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned PCT_W   = 8;
  localparam int unsigned DRIVE_W = 7;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned APB_AW  = 6;
  localparam int unsigned APB_DW  = 64;

  localparam logic [PCT_W-1:0] PCT_MAX      = 8'd100;
  localparam logic [PCT_W-1:0] PCT_FALLBACK = 8'd97;
  localparam logic [PCT_W-1:0] STALL_BUMP   = 8'd10;

  typedef enum logic [1:0] {
    FAN_OFF   = 2'd0,
    FAN_STALL = 2'd1,
    FAN_START = 2'd2,
    FAN_ON    = 2'd3
  } fan_state_e;

  typedef enum logic [2:0] {
    REG_STALL_RPM    = 3'd0,
    REG_STALL_BUMP   = 3'd1,
    REG_STARTUP_MS   = 3'd2,
    REG_STALL_WAIT   = 3'd3,
    REG_MANUAL_MODE  = 3'd4,
    REG_MANUAL_TGT   = 3'd5,
    REG_CURVE_TEMPS  = 3'd6,
    REG_CURVE_PCTS   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_FIRST  = 2'd0,
    CLS_ABOVE  = 2'd1,
    CLS_INTERP = 2'd2,
    CLS_NONE   = 2'd3
  } curve_cls_e;

  typedef enum logic [2:0] {
    C_IDLE   = 3'd0,
    C_EVAL   = 3'd1,
    C_MUL0   = 3'd2,
    C_MUL1   = 3'd3,
    C_DIV_GO = 3'd4,
    C_DIV    = 3'd5,
    C_FIN    = 3'd6
  } ctrl_state_e;

  typedef struct packed {
    logic [15:0] stall_rpm;
    logic [6:0]  stall_bump_limit;
    logic [15:0] startup_ms;
    logic [15:0] stall_wait_ms;
    logic        manual_mode;
    logic [7:0]  manual_target;
    logic [63:0] curve_temps;
    logic [31:0] curve_pcts;
  } fsc_cfg_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul0;
    logic mul1;
    logic div_go;
    logic commit;
  } fsc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } fsc_sts_t;

  function automatic logic [DRIVE_W-1:0] sat100(input logic [PCT_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    r = (v > PCT_MAX) ? PCT_MAX[DRIVE_W-1:0] : v[DRIVE_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/fsc_in_if.sv -----
// tick input channel interface
`default_nettype none

interface fsc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic [15:0]        fan_rpm;
  logic signed [15:0] temperature;

  modport source (output valid, now_ms, fan_rpm, temperature, input ready);
  modport sink (input valid, now_ms, fan_rpm, temperature, output ready);
endinterface

`default_nettype wire

// ----- src/fsc_out_if.sv -----
// result output channel interface
`default_nettype none

interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] drive_pct;
  logic [1:0] fan_state;

  modport source (output valid, drive_pct, fan_state, input ready);
  modport sink (input valid, drive_pct, fan_state, output ready);
endinterface

`default_nettype wire

// ----- src/fsc_regs.sv -----
// apb configuration register file
`default_nettype none

module fsc_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fsc_pkg::APB_AW-1:0] paddr,
  input  wire logic [fsc_pkg::APB_DW-1:0] pwdata,
  output logic      [fsc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output fsc_pkg::fsc_cfg_t               cfg_o
);
  import fsc_pkg::*;

  fsc_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STALL_RPM:   cfg_d.stall_rpm        = pwdata[15:0];
        REG_STALL_BUMP:  cfg_d.stall_bump_limit = pwdata[6:0];
        REG_STARTUP_MS:  cfg_d.startup_ms       = pwdata[15:0];
        REG_STALL_WAIT:  cfg_d.stall_wait_ms    = pwdata[15:0];
        REG_MANUAL_MODE: cfg_d.manual_mode      = pwdata[0];
        REG_MANUAL_TGT:  cfg_d.manual_target    = pwdata[7:0];
        REG_CURVE_TEMPS: cfg_d.curve_temps      = pwdata[63:0];
        REG_CURVE_PCTS:  cfg_d.curve_pcts       = pwdata[31:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STALL_RPM:   prdata = APB_DW'(cfg_q.stall_rpm);
      REG_STALL_BUMP:  prdata = APB_DW'(cfg_q.stall_bump_limit);
      REG_STARTUP_MS:  prdata = APB_DW'(cfg_q.startup_ms);
      REG_STALL_WAIT:  prdata = APB_DW'(cfg_q.stall_wait_ms);
      REG_MANUAL_MODE: prdata = APB_DW'(cfg_q.manual_mode);
      REG_MANUAL_TGT:  prdata = APB_DW'(cfg_q.manual_target);
      REG_CURVE_TEMPS: prdata = cfg_q.curve_temps;
      REG_CURVE_PCTS:  prdata = APB_DW'(cfg_q.curve_pcts);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_rpm        <= 16'd200;
      cfg_q.stall_bump_limit <= 7'd10;
      cfg_q.startup_ms       <= 16'd500;
      cfg_q.stall_wait_ms    <= 16'd2000;
      cfg_q.manual_mode      <= 1'b0;
      cfg_q.manual_target    <= 8'd0;
      cfg_q.curve_temps      <= 64'd0;
      cfg_q.curve_pcts       <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/fsc_div.sv -----
// restoring divider, one quotient bit per cycle, quotient below 256
`default_nettype none

module fsc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [fsc_pkg::NUM_W-1:0] dividend_i,
  input  wire logic [15:0]               divisor_i,
  output logic      [fsc_pkg::PCT_W-1:0] quotient_o,
  output logic                           done_o
);
  import fsc_pkg::*;

  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dvs_q, dvs_d;
  logic [PCT_W-1:0] quo_q, quo_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             fits;

  assign fits       = rem_q >= dvs_q;
  assign quotient_o = quo_q;
  assign done_o     = done_q;

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dvs_d  = {1'b0, divisor_i, 7'b0};
      cnt_d  = 3'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_q - dvs_q : rem_q;
      quo_d = {quo_q[PCT_W-2:0], fits};
      dvs_d = {1'b0, dvs_q[NUM_W-1:1]};
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

endmodule

`default_nettype wire

// ----- src/fsc_dp.sv -----
// datapath: tick latch, curve lookup, fan state update and result register
`default_nettype none

module fsc_dp #(
  parameter int unsigned CURVE_POINTS = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fsc_pkg::fsc_cfg_t          cfg_i,
  input  wire fsc_pkg::fsc_cmd_t          cmd_i,
  output fsc_pkg::fsc_sts_t               sts_o,
  input  wire logic [fsc_pkg::NOW_W-1:0]  now_ms_i,
  input  wire logic [fsc_pkg::RPM_W-1:0]  fan_rpm_i,
  input  wire logic signed [fsc_pkg::TEMP_W-1:0] temperature_i,
  fsc_out_if.source                       out_if
);
  import fsc_pkg::*;

  // tick beat
  logic [NOW_W-1:0]         now_q;
  logic [RPM_W-1:0]         rpm_q;
  logic signed [TEMP_W-1:0] temp_q;

  // curve points
  logic signed [TEMP_W-1:0] ct [CURVE_POINTS];
  logic [PCT_W-1:0]         cp [CURVE_POINTS];
  logic [CURVE_POINTS-2:0]  hit;

  curve_cls_e               cls, cls_q;
  logic signed [TEMP_W-1:0] lo, hi, lo_q, hi_q;
  logic [PCT_W-1:0]         pa, pb, pa_q, pb_q;
  logic                     need_curve;

  // interpolation
  logic signed [TEMP_W:0]   d_hi, d_lo, d_t;
  logic [NUM_W-1:0]         acc_q;
  logic [15:0]              dt_q;
  logic [PCT_W-1:0]         quo;
  logic                     div_done;

  // fan state
  fan_state_e               fan_q, fan_d;
  logic                     entered_q, entered_d;
  logic [DRIVE_W-1:0]       drive_q, drive_d;
  logic [PCT_W-1:0]         target_q, target_d;
  logic [NOW_W-1:0]         mark_q, mark_d;
  logic [PCT_W-1:0]         cv;
  logic                     first;

  // result register
  logic                     ovalid_q;
  logic [DRIVE_W-1:0]       odrive_q;
  fan_state_e               ostate_q;
  logic                     out_free;

  always_comb begin
    for (int k = 0; k < CURVE_POINTS; k++) begin
      ct[k] = cfg_i.curve_temps[16*k +: 16];
      cp[k] = cfg_i.curve_pcts[8*k +: 8];
    end
  end

  always_comb begin
    for (int k = 0; k < CURVE_POINTS - 1; k++) begin
      hit[k] = (temp_q > ct[k]) && (temp_q <= ct[k+1]);
    end
  end

  // first matching interval wins
  always_comb begin
    lo = ct[0];
    hi = ct[1];
    pa = cp[0];
    pb = cp[1];
    for (int k = CURVE_POINTS - 2; k >= 0; k--) begin
      if (hit[k]) begin
        lo = ct[k];
        hi = ct[k+1];
        pa = cp[k];
        pb = cp[k+1];
      end
    end
  end

  always_comb begin
    if (temp_q <= ct[0]) begin
      cls = CLS_FIRST;
    end else if (temp_q > ct[CURVE_POINTS-1]) begin
      cls = CLS_ABOVE;
    end else if (|hit) begin
      cls = CLS_INTERP;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign need_curve = (fan_q == FAN_OFF) || ((fan_q == FAN_ON) && !cfg_i.manual_mode);

  assign d_hi = {hi_q[TEMP_W-1], hi_q} - {temp_q[TEMP_W-1], temp_q};
  assign d_lo = {temp_q[TEMP_W-1], temp_q} - {lo_q[TEMP_W-1], lo_q};
  assign d_t  = {hi_q[TEMP_W-1], hi_q} - {lo_q[TEMP_W-1], lo_q};

  fsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (acc_q),
    .divisor_i  (dt_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    case (cls_q)
      CLS_FIRST:  cv = cp[0];
      CLS_ABOVE:  cv = PCT_MAX;
      CLS_INTERP: cv = quo;
      CLS_NONE:   cv = PCT_FALLBACK;
      default:    cv = PCT_FALLBACK;
    endcase
  end

  assign first = !entered_q;

  always_comb begin
    fan_d    = fan_q;
    drive_d  = drive_q;
    target_d = target_q;
    mark_d   = mark_q;
    case (fan_q)
      FAN_OFF: begin
        if (first) begin
          drive_d = '0;
        end
        target_d = cv;
        if (target_d != '0) begin
          fan_d = FAN_START;
        end
      end
      FAN_STALL: begin
        if (first) begin
          drive_d = '0;
          mark_d  = now_q;
        end
        if (target_q < {1'b0, cfg_i.stall_bump_limit}) begin
          target_d = target_q + STALL_BUMP;
        end
        if ((now_q - mark_d) > NOW_W'(cfg_i.stall_wait_ms)) begin
          fan_d = FAN_START;
        end
      end
      FAN_START: begin
        if (first) begin
          drive_d = PCT_MAX[DRIVE_W-1:0];
          mark_d  = now_q;
        end
        if ((now_q - mark_d) > NOW_W'(cfg_i.startup_ms)) begin
          fan_d = FAN_ON;
        end
      end
      FAN_ON: begin
        target_d = cfg_i.manual_mode ? PCT_W'(sat100(cfg_i.manual_target)) : cv;
        drive_d  = sat100(target_d);
        if (target_d == '0) begin
          fan_d = FAN_OFF;
        end
        if (rpm_q < cfg_i.stall_rpm) begin
          fan_d = FAN_STALL;
        end
      end
      default: fan_d = fan_q;
    endcase
    entered_d = (fan_d == fan_q);
  end

  assign out_free = !ovalid_q || out_if.ready;

  assign sts_o.need_div = need_curve && (cls == CLS_INTERP);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

  assign out_if.valid     = ovalid_q;
  assign out_if.drive_pct = odrive_q;
  assign out_if.fan_state = ostate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q     <= FAN_OFF;
      entered_q <= 1'b1;
      drive_q   <= '0;
      target_q  <= '0;
      mark_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        fan_q     <= fan_d;
        entered_q <= entered_d;
        drive_q   <= drive_d;
        target_q  <= target_d;
        mark_q    <= mark_d;
        ovalid_q  <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q  <= now_ms_i;
      rpm_q  <= fan_rpm_i;
      temp_q <= temperature_i;
    end
    if (cmd_i.eval) begin
      cls_q <= cls;
      lo_q  <= lo;
      hi_q  <= hi;
      pa_q  <= pa;
      pb_q  <= pb;
    end
    if (cmd_i.mul0) begin
      acc_q <= NUM_W'(pa_q * d_hi[TEMP_W-1:0]);
      dt_q  <= d_t[TEMP_W-1:0];
    end
    if (cmd_i.mul1) begin
      acc_q <= acc_q + NUM_W'(pb_q * d_lo[TEMP_W-1:0]);
    end
    if (cmd_i.commit) begin
      odrive_q <= drive_d;
      ostate_q <= fan_d;
    end
  end

  a_drive_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.drive_pct <= PCT_MAX[DRIVE_W-1:0])
    else $error("drive above full scale");

  a_entry_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (entered_q == (fan_q == $past(fan_q))))
    else $error("entry flag out of step with state change");

endmodule

`default_nettype wire

// ----- src/fsc_ctrl.sv -----
// tick sequencer
`default_nettype none

module fsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fsc_pkg::fsc_sts_t sts_i,
  output fsc_pkg::fsc_cmd_t      cmd_o
);
  import fsc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:   if (in_valid_i) state_d = C_EVAL;
      C_EVAL:   state_d = sts_i.need_div ? C_MUL0 : C_FIN;
      C_MUL0:   state_d = C_MUL1;
      C_MUL1:   state_d = C_DIV_GO;
      C_DIV_GO: state_d = C_DIV;
      C_DIV:    if (sts_i.div_done) state_d = C_FIN;
      C_FIN:    if (sts_i.out_free) state_d = C_IDLE;
      default:  state_d = C_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == C_IDLE);
    cmd_o.load_in = (state_q == C_IDLE) && in_valid_i;
    cmd_o.eval    = (state_q == C_EVAL);
    cmd_o.mul0    = (state_q == C_MUL0);
    cmd_o.mul1    = (state_q == C_MUL1);
    cmd_o.div_go  = (state_q == C_DIV_GO);
    cmd_o.commit  = (state_q == C_FIN) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_div_done_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == C_DIV)
    else $error("divider finished outside its wait state");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result written over a pending beat");

endmodule

`default_nettype wire

// ----- src/fan_speed_controller_top.sv -----
// fan speed controller top level
//
// One input beat is a control tick (time, rpm, temperature); each tick gives exactly one
// result beat with the drive percentage and the fan state. A tick passes through the idle,
// eval and fin states, or, when the temperature falls inside a curve segment and the fan
// state uses the curve (off, or on in automatic mode), through idle, eval, mul0, mul1,
// div_go, div and fin; the long case is set by the curve interpolation, two multiply steps
// and an 8-step restoring divider. Ticks are processed one at a time; the next tick is
// accepted once the current one is written to the output register, even if that result is
// not yet taken. A result still waiting in the output register holds the next tick in fin.
// Configuration is written over APB, registers at byte address 8*index, 64-bit data.
`default_nettype none

module fan_speed_controller_top #(
  parameter int unsigned CURVE_POINTS = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fsc_pkg::APB_AW-1:0] paddr,
  input  wire logic [fsc_pkg::APB_DW-1:0] pwdata,
  output logic      [fsc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  fsc_in_if.sink                          in_if,
  fsc_out_if.source                       out_if
);
  import fsc_pkg::*;

  fsc_cfg_t cfg;
  fsc_cmd_t cmd;
  fsc_sts_t sts;
  logic     in_ready;

  assign in_if.ready = in_ready;

  fsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsc_dp #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .now_ms_i      (in_if.now_ms),
    .fan_rpm_i     (in_if.fan_rpm),
    .temperature_i (in_if.temperature),
    .out_if        (out_if)
  );

endmodule

`default_nettype wire
